// ===== hdl/up_down_autoreload_timer_core_defines.svh =====
// assertion macros for the up/down auto-reload timer
`ifndef UP_DOWN_AUTORELOAD_TIMER_CORE_DEFINES_SVH
`define UP_DOWN_AUTORELOAD_TIMER_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define UDT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define UDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define UDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/udt_pkg.sv =====
// shared types and constants of the up/down auto-reload timer
package udt_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } func_t;

  localparam int IDX_W = 8;
  localparam int DATA_W = 32;
  localparam int CTL_W = 10;
  localparam int REP_W = 8;
  localparam int CFG_W = 2;
  localparam int NUM_MISC = 8;
  localparam int NUM_CMP = 4;
  localparam int NUM_CHANNELS = 4;

  // enabled flags that drive the interrupt: update plus one per channel
  localparam logic [DATA_W-1:0] IRQ_MASK =
    DATA_W'((64'd1 << (NUM_CHANNELS + 1)) - 64'd1);

  // control bit positions
  localparam int CTL_EN = 0;
  localparam int CTL_UPDIS = 1;
  localparam int CTL_SPM = 3;
  localparam int CTL_DOWN = 4;

  // register word offsets
  localparam logic [IDX_W-1:0] REG_CTL0 = 8'd0;
  localparam logic [IDX_W-1:0] REG_CTL1 = 8'd1;
  localparam logic [IDX_W-1:0] REG_SMCFG = 8'd2;
  localparam logic [IDX_W-1:0] REG_IRQEN = 8'd3;
  localparam logic [IDX_W-1:0] REG_FLAGS = 8'd4;
  localparam logic [IDX_W-1:0] REG_SWEVT = 8'd5;
  localparam logic [IDX_W-1:0] REG_CHCTL0 = 8'd6;
  localparam logic [IDX_W-1:0] REG_CHCTL1 = 8'd7;
  localparam logic [IDX_W-1:0] REG_CHCTL2 = 8'd8;
  localparam logic [IDX_W-1:0] REG_COUNT = 8'd9;
  localparam logic [IDX_W-1:0] REG_PSC = 8'd10;
  localparam logic [IDX_W-1:0] REG_RELOAD = 8'd11;
  localparam logic [IDX_W-1:0] REG_REPEAT = 8'd12;
  localparam logic [IDX_W-1:0] REG_CMP0 = 8'd13;
  localparam logic [IDX_W-1:0] REG_CMP3 = 8'd16;
  localparam logic [IDX_W-1:0] REG_CCHP = 8'd17;
  localparam logic [IDX_W-1:0] REG_DMACFG = 8'd18;
  localparam logic [IDX_W-1:0] REG_DMATB = 8'd19;
  localparam logic [IDX_W-1:0] REG_CFG = 8'd63;

endpackage

// ===== hdl/up_down_autoreload_timer_core.sv =====
// up/down auto-reload timer core: register file, prescaler and counter
// path: a word is captured in the input register, then its result in the result register
// throughput: one tick, read or write per cycle; a result waiting in the output
//   register does not block the input register, only a full pair stalls
// reset: synchronous, clears the valid flags and timer state, reload goes to all ones
`include "up_down_autoreload_timer_core_defines.svh"

module up_down_autoreload_timer_core #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                func,
  input  logic [udt_pkg::IDX_W-1:0] word_index,
  input  logic [udt_pkg::DATA_W-1:0] write_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [udt_pkg::DATA_W-1:0] read_data,
  output logic                      irq_level
);
  import udt_pkg::*;

  localparam int CW = COUNTER_WIDTH;

  // input register
  logic              s_valid;
  func_t             s_func;
  logic [IDX_W-1:0]  s_index;
  logic [DATA_W-1:0] s_data;

  // handshake control
  logic out_free;
  logic in_free;
  logic go;

  // timer state
  logic [CTL_W-1:0]  ctl, ctl_next;
  logic [DATA_W-1:0] misc [NUM_MISC];
  logic [DATA_W-1:0] misc_next [NUM_MISC];
  logic [DATA_W-1:0] irq_en, irq_en_next;
  logic [DATA_W-1:0] flags, flags_next;
  logic [CW-1:0]     saved_cnt, saved_cnt_next;
  logic [CW-1:0]     psc, psc_next;
  logic [CW-1:0]     reload, reload_next;
  logic [REP_W-1:0]  rep, rep_next;
  logic [CW-1:0]     cmp [NUM_CMP];
  logic [CW-1:0]     cmp_next [NUM_CMP];
  logic [CFG_W-1:0]  cfg, cfg_next;
  logic [CW-1:0]     phase, phase_next;
  logic [CW-1:0]     pos, pos_next;

  // datapath helpers
  logic [CW-1:0]     shown_cnt;
  logic [CW-1:0]     wr_cnt;
  logic [CW-1:0]     wr_clamped;
  logic [1:0]        cmp_sel;
  logic [DATA_W-1:0] rd_next;
  logic              irq_next;

  // output stage takes a new word when empty or when its word leaves;
  // input stage refills when empty or when its word moves on
  assign out_free = !out_valid || !out_stall;
  assign in_free  = !s_valid || out_free;
  assign in_stall = !in_free;
  assign go       = s_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_free) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_free) begin
      s_func  <= func_t'(func);
      s_index <= word_index;
      s_data  <= write_data;
    end
  end

  // count as software sees it: frozen copy when stopped, zero with a zero reload,
  // reload minus position when counting down, so both directions wrap together
  always_comb begin
    if (!ctl[CTL_EN]) begin
      shown_cnt = saved_cnt;
    end else if (reload == '0) begin
      shown_cnt = '0;
    end else if (ctl[CTL_DOWN]) begin
      shown_cnt = reload - pos;
    end else begin
      shown_cnt = pos;
    end
  end

  // a written count sets the running position clamped to the reload rather than reduced
  assign wr_cnt     = s_data[CW-1:0];
  assign wr_clamped = (wr_cnt > reload) ? reload : wr_cnt;
  assign cmp_sel    = 2'(s_index - REG_CMP0);

  // next state and read data for the word in the input register
  always_comb begin
    ctl_next       = ctl;
    misc_next      = misc;
    irq_en_next    = irq_en;
    flags_next     = flags;
    saved_cnt_next = saved_cnt;
    psc_next       = psc;
    reload_next    = reload;
    rep_next       = rep;
    cmp_next       = cmp;
    cfg_next       = cfg;
    phase_next     = phase;
    pos_next       = pos;
    rd_next        = '0;

    if (go) begin
      unique case (s_func)
        FUNC_TICK: begin
          if (ctl[CTL_EN] && (reload != '0)) begin
            if (phase < psc) begin
              phase_next = phase + 1'b1;
            end else begin
              phase_next = '0;
              if (pos < reload) begin
                pos_next = pos + 1'b1;
              end else begin
                // wrap: update flag, and single pulse stops the counter
                pos_next      = '0;
                flags_next[0] = 1'b1;
                if (ctl[CTL_SPM]) begin
                  ctl_next[CTL_EN] = 1'b0;
                  saved_cnt_next   = ctl[CTL_DOWN] ? reload : '0;
                end
              end
            end
          end
        end

        FUNC_READ: begin
          unique case (s_index) inside
            REG_CTL0:            rd_next = DATA_W'(ctl);
            REG_CTL1:            rd_next = misc[0];
            REG_SMCFG:           rd_next = misc[1];
            REG_IRQEN:           rd_next = irq_en;
            REG_FLAGS:           rd_next = flags;
            REG_CHCTL0:          rd_next = misc[2];
            REG_CHCTL1:          rd_next = misc[3];
            REG_CHCTL2:          rd_next = misc[4];
            REG_COUNT:           rd_next = DATA_W'(shown_cnt);
            REG_PSC:             rd_next = DATA_W'(psc);
            REG_RELOAD:          rd_next = DATA_W'(reload);
            REG_REPEAT:          rd_next = DATA_W'(rep);
            [REG_CMP0:REG_CMP3]: rd_next = DATA_W'(cmp[cmp_sel]);
            REG_CCHP:            rd_next = misc[5];
            REG_DMACFG:          rd_next = misc[6];
            REG_DMATB:           rd_next = misc[7];
            REG_CFG:             rd_next = DATA_W'(cfg);
            default:             rd_next = '0;
          endcase
        end

        FUNC_WRITE: begin
          unique case (s_index) inside
            REG_CTL0: begin
              ctl_next = s_data[CTL_W-1:0];
              if (s_data[CTL_EN] && !ctl[CTL_EN]) begin
                // enable edge restarts the count
                pos_next   = '0;
                phase_next = '0;
              end else if (!s_data[CTL_EN] && ctl[CTL_EN]) begin
                // disable edge freezes the count last shown
                saved_cnt_next = shown_cnt;
              end
            end
            REG_CTL1:   misc_next[0] = s_data;
            REG_SMCFG:  misc_next[1] = s_data;
            REG_IRQEN:  irq_en_next = s_data;
            REG_FLAGS:  flags_next = flags & s_data;
            REG_SWEVT: begin
              if (s_data[0]) begin
                pos_next       = '0;
                phase_next     = '0;
                saved_cnt_next = '0;
                if (!ctl[CTL_UPDIS]) begin
                  flags_next[0] = 1'b1;
                end
              end
            end
            REG_CHCTL0: misc_next[2] = s_data;
            REG_CHCTL1: misc_next[3] = s_data;
            REG_CHCTL2: misc_next[4] = s_data;
            REG_COUNT: begin
              saved_cnt_next = wr_cnt;
              if (ctl[CTL_EN]) begin
                pos_next   = ctl[CTL_DOWN] ? (reload - wr_clamped) : wr_clamped;
                phase_next = '0;
              end
            end
            REG_PSC:    psc_next = s_data[CW-1:0];
            REG_RELOAD: begin
              reload_next = s_data[CW-1:0];
              if (pos > s_data[CW-1:0]) begin
                pos_next = s_data[CW-1:0];
              end
            end
            REG_REPEAT: rep_next = s_data[REP_W-1:0];
            [REG_CMP0:REG_CMP3]: cmp_next[cmp_sel] = s_data[CW-1:0];
            REG_CCHP:   misc_next[5] = s_data;
            REG_DMACFG: misc_next[6] = s_data;
            REG_DMATB:  misc_next[7] = s_data;
            REG_CFG:    cfg_next = s_data[CFG_W-1:0];
            default: begin
            end
          endcase
        end

        default: begin
        end
      endcase
    end
  end

  // interrupt level reflects the state after this word
  assign irq_next = |(irq_en_next & flags_next & IRQ_MASK);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl       <= '0;
      misc      <= '{default: '0};
      irq_en    <= '0;
      flags     <= '0;
      saved_cnt <= '0;
      psc       <= '0;
      reload    <= '1;
      rep       <= '0;
      cmp       <= '{default: '0};
      cfg       <= '0;
      phase     <= '0;
      pos       <= '0;
    end else begin
      ctl       <= ctl_next;
      misc      <= misc_next;
      irq_en    <= irq_en_next;
      flags     <= flags_next;
      saved_cnt <= saved_cnt_next;
      psc       <= psc_next;
      reload    <= reload_next;
      rep       <= rep_next;
      cmp       <= cmp_next;
      cfg       <= cfg_next;
      phase     <= phase_next;
      pos       <= pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      read_data <= rd_next;
      irq_level <= irq_next;
    end
  end

  // position never runs past the reload value
  `UDT_ASSERT_ALWAYS(a_pos_within_reload, pos <= reload, "count position above reload")
  // a word leaving the input register always lands in the result register
  `UDT_ASSERT_NEXT(a_word_reaches_output, go, out_valid, "word lost between stages")
  // the counter is only started by a control write
  `UDT_ASSERT_IMP(a_enable_by_write, $rose(ctl[CTL_EN]),
    $past(go && (s_func == FUNC_WRITE) && (s_index == REG_CTL0)), "enable without write")

endmodule
